// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define EMLA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("emla assertion failed");

// clocked assertion that also holds during reset
`define EMLA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("emla assertion failed");

`endif

// File: rtl/emla_pkg.sv
// ----------------------------------------------------------------------------
// emla_pkg
// types, constants and helpers of the encoder menu level adjuster
// ----------------------------------------------------------------------------
package emla_pkg;

   // number of sites with their own colour levels
   localparam int SITES = 9;
   localparam int SLOT_W = (SITES > 1) ? $clog2(SITES) : 1;

   // field widths
   localparam int SITE_W = 4;
   localparam int LEVEL_W = 8;
   localparam int FUNC_W = 3;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX_RESET = 8'd100;

   // register index, taken from the word address
   typedef enum logic [0:0] {
      REG_LEVEL_MAX = 1'b0
   } reg_index_type;

   // menu targets carried in func
   typedef enum logic [FUNC_W-1:0] {
      FUNC_AUTO  = 3'd0,
      FUNC_GRAY  = 3'd1,
      FUNC_SITE  = 3'd2,
      FUNC_RED   = 3'd3,
      FUNC_GREEN = 3'd4,
      FUNC_BLUE  = 3'd5
   } func_type;

   // one memory word: the three levels of one site
   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
   } level_word_type;

   // saturating level step between zero and the limit
   function automatic logic [LEVEL_W-1:0] move_level(
      input logic [LEVEL_W-1:0] level,
      input logic               up,
      input logic [LEVEL_W-1:0] limit
   );
      logic [LEVEL_W-1:0] result;
      if (up) begin
         result = (level < limit) ? level + 1'b1 : limit;
      end else begin
         result = (level != '0) ? level - 1'b1 : level;
      end
      return result;
   endfunction

endpackage

// File: rtl/encoder_menu_level_adjuster.sv
// ----------------------------------------------------------------------------
// encoder_menu_level_adjuster
// rotary encoder detent decoder driving a menu of flags, site and levels
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     content
//  req_      in         tvalid / tready               one encoder edge event
//  rsp_      out        tvalid / tready               state after the event
//  csr_      in/out     psel, penable, pwrite, pready level_max register
//
//  one transaction per cycle in, one per cycle out while the result is not stalled;
//  an event passes stage two, with the registered read of the level memory, then the output register
//  reset clears control state and the valid bits of the level memory
//  a stalled result holds the second stage; input stalls behind it only then
// ----------------------------------------------------------------------------
module encoder_menu_level_adjuster (
   input  logic                                  clock,
   input  logic                                  reset,
   // pin_a [0], pin_b [1], func [4:2], zeros above
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [emla_pkg::REQ_DATA_W-1:0]       req_tdata,
   // site [3:0], red_level [11:4], green_level [19:12], blue_level [27:20],
   // auto_flag [28], gray_flag [29], zeros above
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [emla_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [emla_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [emla_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [emla_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   // input fields
   logic                            pin_a;
   logic                            pin_b;
   logic [emla_pkg::FUNC_W-1:0]     func;

   // configuration
   logic [emla_pkg::LEVEL_W-1:0]    level_max_ff;
   logic                            csr_wr;
   logic                            csr_sel_max;

   // control state
   logic                            armed_ff, armed_in;
   logic [emla_pkg::SITE_W-1:0]     site_ff, site_in;
   logic                            auto_ff, auto_in;
   logic                            gray_ff, gray_in;
   logic                            req_acc;
   logic                            detent;
   logic                            level_op;
   logic [emla_pkg::SLOT_W-1:0]     rd_addr;

   // level memory
   emla_pkg::level_word_type        mem [emla_pkg::SITES];
   logic [emla_pkg::SITES-1:0]      valid_ff;
   emla_pkg::level_word_type        rd_word_ff;
   logic                            byp_ff;
   emla_pkg::level_word_type        byp_word_ff;
   logic                            mem_we;

   // second stage
   logic                            s2_valid_ff, s2_valid_in;
   logic                            s2_adv;
   logic [emla_pkg::SLOT_W-1:0]     s2_slot_ff;
   logic [emla_pkg::SITE_W-1:0]     s2_site_ff;
   logic                            s2_auto_ff;
   logic                            s2_gray_ff;
   logic                            s2_mod_ff;
   logic                            s2_up_ff;
   logic [emla_pkg::FUNC_W-1:0]     s2_func_ff;
   emla_pkg::level_word_type        cur_word;
   emla_pkg::level_word_type        new_word;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [emla_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign pin_a = req_tdata[0];
   assign pin_b = req_tdata[1];
   assign func  = req_tdata[4:2];

   // configuration write and read
   assign csr_pready  = 1'b1;
   assign csr_sel_max = (csr_paddr[2] == emla_pkg::REG_LEVEL_MAX);
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata  = csr_sel_max ?
                        {{(emla_pkg::CSR_DATA_W-emla_pkg::LEVEL_W){1'b0}}, level_max_ff} :
                        '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_max_ff <= emla_pkg::LEVEL_MAX_RESET;
      end else if (csr_wr && csr_sel_max) begin
         level_max_ff <= csr_pwdata[emla_pkg::LEVEL_W-1:0];
      end
   end

   // handshake
   assign s2_adv     = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s2_valid_ff || s2_adv;
   assign req_acc    = req_tvalid && req_tready;

   // detent decoder, flags and site update
   always_comb begin
      armed_in = armed_ff;
      site_in  = site_ff;
      auto_in  = auto_ff;
      gray_in  = gray_ff;
      detent   = 1'b0;
      level_op = 1'b0;
      if (req_acc && (func <= emla_pkg::FUNC_BLUE)) begin
         if (func >= emla_pkg::FUNC_SITE) begin
            auto_in = 1'b0;
            gray_in = 1'b0;
         end
         if (!pin_a) begin
            armed_in = 1'b1;
         end else if (armed_ff) begin
            armed_in = 1'b0;
            detent   = 1'b1;
         end
      end
      if (detent) begin
         case (func)
            emla_pkg::FUNC_AUTO: begin
               auto_in = pin_b;
            end
            emla_pkg::FUNC_GRAY: begin
               gray_in = pin_b;
            end
            emla_pkg::FUNC_SITE: begin
               if (pin_b) begin
                  site_in = (site_ff < emla_pkg::SITE_W'(emla_pkg::SITES)) ?
                            site_ff + 1'b1 : emla_pkg::SITE_W'(emla_pkg::SITES);
               end else begin
                  site_in = (site_ff > emla_pkg::SITE_W'(1)) ?
                            site_ff - 1'b1 : emla_pkg::SITE_W'(1);
               end
            end
            default: begin
               level_op = 1'b1;
            end
         endcase
      end
   end

   // slot of the site after this event
   assign rd_addr = emla_pkg::SLOT_W'(site_in - emla_pkg::SITE_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         site_ff  <= emla_pkg::SITE_W'(1);
         auto_ff  <= 1'b0;
         gray_ff  <= 1'b0;
      end else begin
         armed_ff <= armed_in;
         site_ff  <= site_in;
         auto_ff  <= auto_in;
         gray_ff  <= gray_in;
      end
   end

   // level memory: write back from stage two, registered read on accept
   assign mem_we = s2_adv && s2_mod_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s2_slot_ff] <= new_word;
      end
      if (req_acc) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[s2_slot_ff] <= 1'b1;
      end
   end

   // forwarding of a write to the entry read in the same cycle, zero for an entry never written
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (mem_we && (s2_slot_ff == rd_addr)) begin
            byp_ff      <= 1'b1;
            byp_word_ff <= new_word;
         end else if (!valid_ff[rd_addr]) begin
            byp_ff      <= 1'b1;
            byp_word_ff <= '0;
         end else begin
            byp_ff      <= 1'b0;
            byp_word_ff <= '0;
         end
      end
   end

   // stage two payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s2_slot_ff <= rd_addr;
         s2_site_ff <= site_in;
         s2_auto_ff <= auto_in;
         s2_gray_ff <= gray_in;
         s2_mod_ff  <= level_op;
         s2_up_ff   <= pin_b;
         s2_func_ff <= func;
      end
   end

   assign s2_valid_in = req_acc || (s2_valid_ff && !s2_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // level modify
   assign cur_word = byp_ff ? byp_word_ff : rd_word_ff;

   always_comb begin
      new_word = cur_word;
      case (s2_func_ff)
         emla_pkg::FUNC_RED: begin
            new_word.red = emla_pkg::move_level(cur_word.red, s2_up_ff, level_max_ff);
         end
         emla_pkg::FUNC_GREEN: begin
            new_word.green = emla_pkg::move_level(cur_word.green, s2_up_ff, level_max_ff);
         end
         emla_pkg::FUNC_BLUE: begin
            new_word.blue = emla_pkg::move_level(cur_word.blue, s2_up_ff, level_max_ff);
         end
         default: begin
            new_word = cur_word;
         end
      endcase
      if (!s2_mod_ff) begin
         new_word = cur_word;
      end
   end

   // output register
   assign rsp_valid_in = s2_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_data_ff <= {2'b00, s2_gray_ff, s2_auto_ff, new_word.blue,
                         new_word.green, new_word.red, s2_site_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/emla_checker.sv
// ----------------------------------------------------------------------------
// emla_checker
// port-level checks on the encoder menu level adjuster
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emla_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [emla_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result holds its value
   `EMLA_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // a new result follows an accepted event that passed stage two and the output register
   `EMLA_ASSERT(a_rsp_follows_req, clock, reset, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))

   // the reported site stays within the saturation range
   `EMLA_ASSERT(a_site_range, clock, reset, rsp_tvalid |-> (rsp_tdata[3:0] >= 4'd1) && (rsp_tdata[3:0] <= 4'(emla_pkg::SITES)))

   // no result is left over from before reset
   `EMLA_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind encoder_menu_level_adjuster emla_checker u_emla_checker (.*);

// File: tb/encoder_menu_level_adjuster_tb.sv
// ----------------------------------------------------------------------------
// encoder_menu_level_adjuster_tb
// streams encoder edge events into the menu level adjuster, predicts the menu
// state after every event and checks each returned status transaction field
// by field, across several level limits and sender and receiver idle patterns
// ----------------------------------------------------------------------------
module encoder_menu_level_adjuster_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import emla_pkg::*;

   // menu targets that the block ignores
   localparam logic [FUNC_W-1:0] FUNC_NONE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_NONE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_EDGES = 68;

   // status word as carried in rsp_tdata, highest field first
   typedef struct packed {
      logic               gray_flag;
      logic               auto_flag;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [SITE_W-1:0]  site;
   } menu_status_type;

   // tracks the menu state and holds the status words still to come back
   class menu_tracker;
      logic [LEVEL_W-1:0] limit;
      logic               armed;
      logic [SITE_W-1:0]  site;
      logic [LEVEL_W-1:0] red[SITES];
      logic [LEVEL_W-1:0] green[SITES];
      logic [LEVEL_W-1:0] blue[SITES];
      logic               auto_on;
      logic               gray_on;
      menu_status_type    pending_status[$];
      int                 errors;
      int                 checked;

      function new();
         limit = LEVEL_MAX_RESET;
         armed = 1'b0;
         site = 4'd1;
         foreach (red[i]) begin
            red[i] = '0;
            green[i] = '0;
            blue[i] = '0;
         end
         auto_on = 1'b0;
         gray_on = 1'b0;
         errors = 0;
         checked = 0;
      endfunction

      function void set_limit(input logic [LEVEL_W-1:0] value);
         limit = value;
      endfunction

      // saturating level step, up to the limit and down to zero
      function logic [LEVEL_W-1:0] step_level(input logic [LEVEL_W-1:0] lv, input logic up);
         if (up) begin
            return (lv < limit) ? lv + 8'd1 : limit;
         end
         return (lv != '0) ? lv - 8'd1 : lv;
      endfunction

      function void report(input string what, input int exp_v, input int act_v);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("%0t: %s differs: expected %0d, got %0d", $realtime, what, exp_v, act_v);
         end
      endfunction

      // one accepted edge event
      function void apply_edge(input logic a, input logic up, input logic [FUNC_W-1:0] f);
         int              slot;
         menu_status_type status;
         if (f <= FUNC_BLUE) begin
            // level and site targets drop both flags on every event
            if (f >= FUNC_SITE) begin
               auto_on = 1'b0;
               gray_on = 1'b0;
            end
            if (!a) begin
               armed = 1'b1;
            end else if (armed) begin
               // detent completed
               armed = 1'b0;
               slot = site - 1;
               case (func_type'(f))
                  FUNC_AUTO: auto_on = up;
                  FUNC_GRAY: gray_on = up;
                  FUNC_SITE: begin
                     if (up) begin
                        if (site < SITES) site = site + 4'd1;
                     end else begin
                        if (site > 1) site = site - 4'd1;
                     end
                  end
                  FUNC_RED:   red[slot] = step_level(red[slot], up);
                  FUNC_GREEN: green[slot] = step_level(green[slot], up);
                  default:    blue[slot] = step_level(blue[slot], up);
               endcase
            end
         end
         slot = site - 1;
         status.site = site;
         status.red = red[slot];
         status.green = green[slot];
         status.blue = blue[slot];
         status.auto_flag = auto_on;
         status.gray_flag = gray_on;
         pending_status.push_back(status);
      endfunction

      // one returned status transaction
      function void check_status(input logic [RSP_DATA_W-1:0] data);
         menu_status_type exp_s;
         menu_status_type act_s;
         checked++;
         if (pending_status.size() == 0) begin
            report("unexpected status transaction, site", 0, data[SITE_W-1:0]);
            return;
         end
         exp_s = pending_status.pop_front();
         act_s = data[$bits(menu_status_type)-1:0];
         if (act_s.site != exp_s.site) report("site", exp_s.site, act_s.site);
         if (act_s.red != exp_s.red) report("red_level", exp_s.red, act_s.red);
         if (act_s.green != exp_s.green) report("green_level", exp_s.green, act_s.green);
         if (act_s.blue != exp_s.blue) report("blue_level", exp_s.blue, act_s.blue);
         if (act_s.auto_flag != exp_s.auto_flag) begin
            report("auto_flag", exp_s.auto_flag, act_s.auto_flag);
         end
         if (act_s.gray_flag != exp_s.gray_flag) begin
            report("gray_flag", exp_s.gray_flag, act_s.gray_flag);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   menu_tracker tracker;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          edges_sent;
   int          active_edges;
   int          climbs;

   encoder_menu_level_adjuster u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always #4 clock = ~clock;

   // receiver stalls, decided once per cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // status transactions and run limit
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_status(rsp_tdata);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d status words outstanding",
                  cycle_count, tracker.pending_status.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // number of idle cycles before the next edge
   function automatic int draw_gap(input int pct);
      int n;
      n = 0;
      while (n < 60 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   // one edge event, entered and left just after a falling edge
   task automatic send_edge(input logic a, input logic b, input logic [FUNC_W-1:0] f);
      int gap;
      gap = draw_gap(send_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, f, b, a};
      do @(posedge clock); while (!req_tready);
      tracker.apply_edge(a, b, f);
      edges_sent++;
      if (f <= FUNC_BLUE) active_edges++;
      @(negedge clock);
   endtask

   // well-formed detent: arm on low A, complete on high A
   task automatic detent(input logic [FUNC_W-1:0] f, input logic up);
      send_edge(1'b0, 1'($urandom_range(1)), f);
      send_edge(1'b1, up, f);
   endtask

   // wait for every outstanding status word, sender idle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write of level_max followed by a read back
   task automatic write_limit(input logic [LEVEL_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr = {REG_LEVEL_MAX, 2'b00};
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {{(CSR_DATA_W-LEVEL_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tracker.set_limit(value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[LEVEL_W-1:0] !== value) begin
         tracker.report("level_max read back", value, csr_prdata[LEVEL_W-1:0]);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // random traffic: mostly detent runs with a direction bias, some noise
   task automatic random_traffic(input int budget);
      int                 start;
      int                 run_len;
      int                 up_pct;
      logic [FUNC_W-1:0]  f;
      start = active_edges;
      while (active_edges - start < budget) begin
         if ($urandom_range(99) < 80) begin
            f = 3'($urandom_range(7));
            run_len = $urandom_range(1, 12);
            case ($urandom_range(2))
               0: up_pct = 10;
               1: up_pct = 50;
               default: up_pct = 90;
            endcase
            repeat (run_len) detent(f, $urandom_range(99) < up_pct);
         end else begin
            // broken sequences: lone edges, double arms, target switches
            repeat ($urandom_range(1, 4)) begin
               send_edge(1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom_range(7)));
            end
         end
      end
   endtask

   // push one colour of the current site to the top of a 255 limit
   task automatic climb(input logic [FUNC_W-1:0] f);
      repeat (256) detent(f, 1'b1);
      climbs++;
   endtask

   initial begin
      logic [LEVEL_W-1:0] limits[8];
      logic [FUNC_W-1:0]  colour;
      int                 mode;

      limits = '{8'd1, 8'd255, 8'd20, 8'd0, 8'd128, 8'd255, 8'd7, 8'd100};
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      edges_sent = 0;
      active_edges = 0;
      climbs = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset limit
      send_edge(1'b1, 1'b1, FUNC_AUTO);        // high A without arming
      detent(FUNC_AUTO, 1'b1);
      detent(FUNC_GRAY, 1'b1);
      detent(FUNC_AUTO, 1'b0);
      send_edge(1'b0, 1'b1, FUNC_NONE_LO);     // ignored, does not arm
      send_edge(1'b1, 1'b1, FUNC_AUTO);
      send_edge(1'b0, 1'b1, FUNC_NONE_HI);
      detent(FUNC_RED, 1'b0);                  // level at the bottom, flags cleared
      detent(FUNC_SITE, 1'b0);                 // site at the bottom
      detent(FUNC_RED, 1'b1);
      detent(FUNC_GREEN, 1'b1);
      detent(FUNC_BLUE, 1'b1);
      detent(FUNC_SITE, 1'b1);
      send_edge(1'b0, 1'b0, FUNC_BLUE);        // double arm
      detent(FUNC_BLUE, 1'b1);
      drain();

      // one phase per limit, idle pattern rotating
      foreach (limits[p]) begin
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 23 : 0;
         recv_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 23 : 0;
         write_limit(limits[p]);
         // probe each colour around the new limit, also above it
         for (int c = FUNC_RED; c <= FUNC_BLUE; c++) begin
            detent(3'(c), 1'b1);
            detent(3'(c), 1'b0);
            detent(3'(c), 1'b0);
         end
         random_traffic(PHASE_EDGES);
         if (limits[p] == 8'd255 && climbs == 0) begin
            colour = 3'($urandom_range(FUNC_RED, FUNC_BLUE));
            climb(colour);
         end
         drain();
      end

      // settle after the last status word
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      $display("%0d edge events sent (%0d to active targets), %0d status words checked",
               edges_sent, active_edges, tracker.checked);
      $display("limits 0 to 255 exercised under four idle patterns, %0d full climb(s)",
               climbs);
      if (tracker.errors == 0 && tracker.pending_status.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d field errors", tracker.errors);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
